// ===== design/pmb_pkg.sv =====
// ----------------------------------------------------------------------------
// pmb_pkg
// Shared types and constants for the peak meter ballistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmb_pkg;

	// field widths
	localparam int unsigned PeakInW   = 22;
	localparam int unsigned ClipCntW  = 32;
	localparam int unsigned LevelW    = 19;
	localparam int unsigned FactorW   = 16;
	localparam int unsigned TicksW    = 8;
	localparam int unsigned ThreshW   = 16;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned InDataW   = 56;
	localparam int unsigned OutDataW  = 40;

	// full scale 4.0 in Q3.16
	localparam logic [LevelW-1:0] PeakMax = 19'd262144;

	// register reset values
	localparam logic [FactorW-1:0] ReleaseFactorRst   = 16'd60694;
	localparam logic [TicksW-1:0]  HoldTicksRst       = 8'd45;
	localparam logic [TicksW-1:0]  ClipHoldTicksRst   = 8'd60;
	localparam logic [ThreshW-1:0] ChangeThresholdRst = 16'd33;

	// register indexes
	typedef enum logic [CfgIndexW-1:0] {
		REG_RELEASE_FACTOR   = 2'd0,
		REG_HOLD_TICKS       = 2'd1,
		REG_CLIP_HOLD_TICKS  = 2'd2,
		REG_CHANGE_THRESHOLD = 2'd3
	} pmb_reg_t;

	typedef struct packed {
		logic [FactorW-1:0] release_factor;
		logic [TicksW-1:0]  hold_ticks;
		logic [TicksW-1:0]  clip_hold_ticks;
		logic [ThreshW-1:0] change_threshold;
	} pmb_cfg_t;

	// result item, level in the lowest bits
	typedef struct packed {
		logic              redraw;
		logic              clip_recent;
		logic [LevelW-1:0] hold_level;
		logic [LevelW-1:0] level;
	} pmb_result_t;

endpackage

`default_nettype wire

// ===== design/peak_meter_ballistics.sv =====
// ----------------------------------------------------------------------------
// peak_meter_ballistics
// Peak level meter with peak hold and clip indicator, one item per meter tick.
// ----------------------------------------------------------------------------
// Each accepted tick gives exactly one result item. The block takes one item
// per clock cycle while the output is not stalled; an item passes through the
// input register, then the state update into the output register. The rate
// is set by the meter state loop, whose release multiply, attack/hold
// compares and redraw compares all lie in one combinational path. While the
// output is stalled, one further item is still taken into the input register.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// should change only while no item is in flight.
`default_nettype none

module peak_meter_ballistics (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write port
	input  wire logic                         cfg_we,
	input  wire logic [pmb_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [pmb_pkg::CfgDataW-1:0]  cfg_wdata,
	// input stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [pmb_pkg::InDataW-1:0]  s_tdata,  // instant_peak[21:0], clip_count[53:22], zero pad
	// result stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [pmb_pkg::OutDataW-1:0]      m_tdata   // level[18:0], hold_level[37:19], clip_recent[38], redraw[39]
);
	import pmb_pkg::*;

	pmb_cfg_t    cfg;
	pmb_result_t result;
	pmb_result_t out_q;

	logic                s1_valid_q;
	logic [PeakInW-1:0]  peak_s1;
	logic [ClipCntW-1:0] clips_s1;
	logic                out_valid_q;
	logic                advance;

	pmb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// pipeline control
	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			peak_s1  <= s_tdata[PeakInW-1:0];
			clips_s1 <= s_tdata[PeakInW+ClipCntW-1:PeakInW];
		end
	end

	pmb_ballistics u_ballistics (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (advance),
		.instant_peak (peak_s1),
		.clip_count   (clips_s1),
		.result       (result)
	);

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// the level never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.level <= PeakMax))
		else $error("level above full scale");

	// the hold never sits below the level
	a_hold_above_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.hold_level >= out_q.level))
		else $error("hold below level");

	// input stalls only when both registers are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q && !m_tready))
		else $error("input stalled without cause");

	// a result is valid in the cycle after the state steps
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("state stepped without a result");

endmodule

`default_nettype wire

// ===== design/pmb_cfg.sv =====
// ----------------------------------------------------------------------------
// pmb_cfg
// Configuration register file, written one register per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmb_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [pmb_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [pmb_pkg::CfgDataW-1:0]  cfg_wdata,
	output pmb_pkg::pmb_cfg_t                  cfg
);
	import pmb_pkg::*;

	pmb_cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_factor   <= ReleaseFactorRst;
			cfg_q.hold_ticks       <= HoldTicksRst;
			cfg_q.clip_hold_ticks  <= ClipHoldTicksRst;
			cfg_q.change_threshold <= ChangeThresholdRst;
		end else if (cfg_we) begin
			unique case (pmb_reg_t'(cfg_index))
				REG_RELEASE_FACTOR:   cfg_q.release_factor   <= cfg_wdata[FactorW-1:0];
				REG_HOLD_TICKS:       cfg_q.hold_ticks       <= cfg_wdata[TicksW-1:0];
				REG_CLIP_HOLD_TICKS:  cfg_q.clip_hold_ticks  <= cfg_wdata[TicksW-1:0];
				REG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_wdata[ThreshW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/pmb_ballistics.sv =====
// ----------------------------------------------------------------------------
// pmb_ballistics
// Meter state and the per-tick update: attack, release, peak hold, clip timer.
// ----------------------------------------------------------------------------
`default_nettype none

module pmb_ballistics (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  pmb_pkg::pmb_cfg_t                 cfg,
	input  wire logic                         step,
	input  wire logic [pmb_pkg::PeakInW-1:0]  instant_peak,
	input  wire logic [pmb_pkg::ClipCntW-1:0] clip_count,
	output pmb_pkg::pmb_result_t              result
);
	import pmb_pkg::*;

	logic [LevelW-1:0]   level_q;
	logic [LevelW-1:0]   hold_q;
	logic [TicksW-1:0]   hold_cnt_q;
	logic [ClipCntW-1:0] last_clips_q;
	logic [TicksW-1:0]   clip_cnt_q;
	logic                clip_flag_q;

	logic [LevelW-1:0]   peak_sat;
	logic [LevelW+FactorW-1:0] level_prod;
	logic [LevelW+FactorW-1:0] hold_prod;
	logic [LevelW-1:0]   level_rel;
	logic [LevelW-1:0]   hold_rel;
	logic [LevelW-1:0]   level_nx;
	logic [LevelW-1:0]   hold_nx;
	logic [TicksW-1:0]   hold_cnt_nx;
	logic [TicksW-1:0]   clip_cnt_nx;
	logic                clip_change;
	logic                clip_flag_nx;
	logic [LevelW-1:0]   level_diff;
	logic [LevelW-1:0]   hold_diff;

	// clamp to full scale
	assign peak_sat = (instant_peak > {{(PeakInW-LevelW){1'b0}}, PeakMax}) ?
		PeakMax : instant_peak[LevelW-1:0];

	// release multiplies, truncated toward zero
	assign level_prod = {{FactorW{1'b0}}, level_q} * {{LevelW{1'b0}}, cfg.release_factor};
	assign hold_prod  = {{FactorW{1'b0}}, hold_q} * {{LevelW{1'b0}}, cfg.release_factor};
	assign level_rel  = level_prod[LevelW+FactorW-1:FactorW];
	assign hold_rel   = hold_prod[LevelW+FactorW-1:FactorW];

	// instant attack, multiplicative release
	assign level_nx = (peak_sat > level_rel) ? peak_sat : level_rel;

	// peak hold: refresh, count down, then decay no lower than the level
	always_comb begin
		priority if (level_nx >= hold_q) begin
			hold_nx     = level_nx;
			hold_cnt_nx = cfg.hold_ticks;
		end else if (hold_cnt_q <= 8'd1) begin
			hold_cnt_nx = '0;
			hold_nx     = (level_nx > hold_rel) ? level_nx : hold_rel;
		end else begin
			hold_cnt_nx = hold_cnt_q - 8'd1;
			hold_nx     = hold_q;
		end
	end

	// clip indicator countdown
	assign clip_change = (clip_count != last_clips_q);
	always_comb begin
		priority if (clip_change) begin
			clip_cnt_nx = cfg.clip_hold_ticks;
		end else if (clip_cnt_q != '0) begin
			clip_cnt_nx = clip_cnt_q - 8'd1;
		end else begin
			clip_cnt_nx = clip_cnt_q;
		end
	end
	assign clip_flag_nx = (clip_cnt_nx != '0);

	// redraw on notable movement
	assign level_diff = (level_nx > level_q) ? level_nx - level_q : level_q - level_nx;
	assign hold_diff  = (hold_nx > hold_q) ? hold_nx - hold_q : hold_q - hold_nx;

	always_comb begin
		result.level       = level_nx;
		result.hold_level  = hold_nx;
		result.clip_recent = clip_flag_nx;
		result.redraw      = (level_diff > {{(LevelW-ThreshW){1'b0}}, cfg.change_threshold})
			|| (hold_diff > {{(LevelW-ThreshW){1'b0}}, cfg.change_threshold})
			|| (clip_flag_nx != clip_flag_q);
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			hold_q       <= '0;
			hold_cnt_q   <= '0;
			last_clips_q <= '0;
			clip_cnt_q   <= '0;
			clip_flag_q  <= 1'b0;
		end else if (step) begin
			level_q      <= level_nx;
			hold_q       <= hold_nx;
			hold_cnt_q   <= hold_cnt_nx;
			last_clips_q <= clip_count;
			clip_cnt_q   <= clip_cnt_nx;
			clip_flag_q  <= clip_flag_nx;
		end
	end

endmodule

`default_nettype wire
